[rtl/core/hms_pkg.sv]
// ----------------------------------------------------------------------------
// hms_pkg
// Shared types and constants for the axis homing motion step core.
// ----------------------------------------------------------------------------
package hms_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned TILE_W  = 16;
   localparam int unsigned ADDR_W  = 3;
   localparam int unsigned DIV_CELLS = DATA_W;

   localparam logic [1:0] MODE_X = 2'd0;
   localparam logic [1:0] MODE_Y = 2'd1;

   // register index as decoded from paddr[2]
   localparam logic REG_TILE_X = 1'b0;
   localparam logic REG_TILE_Y = 1'b1;

   localparam logic [TILE_W-1:0] TILE_SIZE_RESET = TILE_W'(16);

   // one request as it travels down the divider chain
   typedef struct packed {
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] velocity;
      logic                     arrived;
      logic                     tile_valid;
      logic                     neg;
      logic                     div_zero;
      logic [TILE_W-1:0]        divisor;
      logic [DATA_W-1:0]        num;
      logic [TILE_W-1:0]        rem;
   } hms_item_type;

endpackage

[rtl/core/hms_if.sv]
// ----------------------------------------------------------------------------
// hms_req_if / hms_rsp_if
// Valid/ready channels for requests and results of the homing step core.
// ----------------------------------------------------------------------------
interface hms_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic               homing_on;
   logic               axis_on;
   logic signed [31:0] position_now;
   logic signed [31:0] velocity_now;
   logic signed [31:0] accel;
   logic signed [31:0] goal;

   modport source (
      output valid, mode, homing_on, axis_on, position_now, velocity_now, accel, goal,
      input  ready
   );
   modport sink (
      input  valid, mode, homing_on, axis_on, position_now, velocity_now, accel, goal,
      output ready
   );
endinterface

interface hms_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] position_new;
   logic signed [31:0] velocity_new;
   logic               arrived;
   logic signed [31:0] tile_index;
   logic               tile_valid;

   modport source (
      output valid, position_new, velocity_new, arrived, tile_index, tile_valid,
      input  ready
   );
   modport sink (
      input  valid, position_new, velocity_new, arrived, tile_index, tile_valid,
      output ready
   );
endinterface

[rtl/core/hms_motion.sv]
// ----------------------------------------------------------------------------
// hms_motion
// Three-stage front end: velocity update, position update with goal snap,
// and preparation of the divider operand.
// ----------------------------------------------------------------------------
module hms_motion
   import hms_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   hms_req_if.sink           req_ch,
   input  logic [TILE_W-1:0] tile_size_x,
   input  logic [TILE_W-1:0] tile_size_y,
   output logic              out_valid,
   input  logic              out_ready,
   output hms_item_type      out_item
);

   // stage 1: velocity
   logic                     v1_ff;
   logic signed [DATA_W-1:0] pos1_ff, vel1_ff, goal1_ff;
   logic                     act1_ff, tv1_ff;
   logic [TILE_W-1:0]        div1_ff;
   // stage 2: position
   logic                     v2_ff;
   logic signed [DATA_W-1:0] pos2_ff, vel2_ff;
   logic                     arr2_ff, tv2_ff;
   logic [TILE_W-1:0]        div2_ff;
   // stage 3: divider operand
   logic                     v3_ff;
   hms_item_type             item3_ff;

   logic ready1, ready2, ready3;
   logic                     act_in;
   logic signed [DATA_W-1:0] step_in, vel1_in;
   logic signed [DATA_W-1:0] moved, pos2_in;
   logic                     keep;
   hms_item_type             item3_in;

   assign ready3 = !v3_ff || out_ready;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign req_ch.ready = ready1;

   always_comb begin
      act_in  = req_ch.homing_on && req_ch.axis_on;
      // accelerate back toward the goal once at or past it
      step_in = (req_ch.position_now >= req_ch.goal) ? -req_ch.accel : req_ch.accel;
      vel1_in = act_in ? (req_ch.velocity_now + step_in) : req_ch.velocity_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (ready1) begin
         v1_ff <= req_ch.valid;
      end
      if (ready1 && req_ch.valid) begin
         pos1_ff  <= req_ch.position_now;
         vel1_ff  <= vel1_in;
         goal1_ff <= req_ch.goal;
         act1_ff  <= act_in;
         tv1_ff   <= req_ch.homing_on && (req_ch.mode == MODE_X || req_ch.mode == MODE_Y);
         div1_ff  <= (req_ch.mode == MODE_X) ? tile_size_x : tile_size_y;
      end
   end

   always_comb begin
      moved   = pos1_ff + vel1_ff;
      keep    = (vel1_ff > 0 && moved < goal1_ff) || (vel1_ff < 0 && moved > goal1_ff);
      pos2_in = !act1_ff ? pos1_ff : (keep ? moved : goal1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (ready2) begin
         v2_ff <= v1_ff;
      end
      if (ready2 && v1_ff) begin
         pos2_ff <= pos2_in;
         vel2_ff <= vel1_ff;
         arr2_ff <= act1_ff && !keep;
         tv2_ff  <= tv1_ff;
         div2_ff <= div1_ff;
      end
   end

   always_comb begin
      item3_in.position   = pos2_ff;
      item3_in.velocity   = vel2_ff;
      item3_in.arrived    = arr2_ff;
      item3_in.tile_valid = tv2_ff;
      item3_in.neg        = pos2_ff[DATA_W-1];
      item3_in.div_zero   = (div2_ff == '0);
      item3_in.divisor    = div2_ff;
      // magnitude; the most negative value maps onto itself as unsigned
      item3_in.num        = pos2_ff[DATA_W-1] ? DATA_W'(-pos2_ff) : DATA_W'(pos2_ff);
      item3_in.rem        = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (ready3) begin
         v3_ff <= v2_ff;
      end
      if (ready3 && v2_ff) begin
         item3_ff <= item3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = item3_ff;

endmodule

[rtl/core/hms_div_cell.sv]
// ----------------------------------------------------------------------------
// hms_div_cell
// One restoring-division cell: brings in one dividend bit, produces one
// quotient bit, and hands the request to the next cell.
// ----------------------------------------------------------------------------
module hms_div_cell
   import hms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  hms_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output hms_item_type out_item
);

   logic         valid_ff;
   hms_item_type item_ff;
   hms_item_type item_in;
   logic [TILE_W:0] part_rem;
   logic [TILE_W:0] diff;
   logic            fits;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      part_rem = {in_item.rem, in_item.num[DATA_W-1]};
      diff     = part_rem - {1'b0, in_item.divisor};
      fits     = (part_rem >= {1'b0, in_item.divisor});
      item_in      = in_item;
      // quotient bits fill in from the bottom as dividend bits leave the top
      item_in.num  = {in_item.num[DATA_W-2:0], fits};
      item_in.rem  = fits ? diff[TILE_W-1:0] : part_rem[TILE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

[rtl/core/hms_finish.sv]
// ----------------------------------------------------------------------------
// hms_finish
// Applies the quotient sign, zeroes the tile index where it does not apply,
// and holds the result register toward the response channel.
// ----------------------------------------------------------------------------
module hms_finish
   import hms_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  hms_item_type in_item,
   hms_rsp_if.source    rsp_ch
);

   logic                     valid_ff;
   logic signed [DATA_W-1:0] pos_ff, vel_ff, tile_ff;
   logic                     arr_ff, tv_ff;
   logic signed [DATA_W-1:0] tile_in;

   assign in_ready = !valid_ff || rsp_ch.ready;

   always_comb begin
      if (!in_item.tile_valid || in_item.div_zero) begin
         tile_in = '0;
      end else if (in_item.neg) begin
         tile_in = -$signed(in_item.num);
      end else begin
         tile_in = $signed(in_item.num);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         pos_ff  <= in_item.position;
         vel_ff  <= in_item.velocity;
         arr_ff  <= in_item.arrived;
         tile_ff <= tile_in;
         tv_ff   <= in_item.tile_valid;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.position_new = pos_ff;
   assign rsp_ch.velocity_new = vel_ff;
   assign rsp_ch.arrived      = arr_ff;
   assign rsp_ch.tile_index   = tile_ff;
   assign rsp_ch.tile_valid   = tv_ff;

endmodule

[rtl/core/axis_homing_motion_step_core.sv]
// ----------------------------------------------------------------------------
// axis_homing_motion_step_core
// Per-axis homing step: velocity and position update toward a goal, with a
// signed tile index taken through a chain of division cells.
// ----------------------------------------------------------------------------
//  channel  direction  handshake          contents
//  req_ch   in         valid/ready        mode, enables, position, velocity,
//                                         accel, goal
//  rsp_ch   out        valid/ready        new position/velocity, arrived,
//                                         tile index and its valid
//  csr_*    in         apb write/read     tile_size_x @0x0, tile_size_y @0x4
//
//  one request per cycle unless rsp_ch stalls; the path is three motion
//  stages, 32 division cells (one quotient bit each), one result register.
//  each stage holds its own valid bit, so a stalled result only stops the
//  stages behind it once they fill up.
//  reset clears all valid bits and sets both tile sizes to 16.
// ----------------------------------------------------------------------------
module axis_homing_motion_step_core
   import hms_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   hms_req_if.sink           req_ch,
   hms_rsp_if.source         rsp_ch,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [TILE_W-1:0] tile_x_ff, tile_y_ff;
   logic              csr_wr;

   logic         chain_valid [DIV_CELLS+1];
   logic         chain_ready [DIV_CELLS+1];
   hms_item_type chain_item  [DIV_CELLS+1];

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_x_ff <= TILE_SIZE_RESET;
         tile_y_ff <= TILE_SIZE_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_TILE_X: tile_x_ff <= csr_pwdata[TILE_W-1:0];
            REG_TILE_Y: tile_y_ff <= csr_pwdata[TILE_W-1:0];
            default:    ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_TILE_X: csr_prdata = {{(32-TILE_W){1'b0}}, tile_x_ff};
         REG_TILE_Y: csr_prdata = {{(32-TILE_W){1'b0}}, tile_y_ff};
         default:    csr_prdata = '0;
      endcase
   end

   hms_motion u_motion (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .tile_size_x (tile_x_ff),
      .tile_size_y (tile_y_ff),
      .out_valid   (chain_valid[0]),
      .out_ready   (chain_ready[0]),
      .out_item    (chain_item[0])
   );

   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
      hms_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_item   (chain_item[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_item  (chain_item[i+1])
      );
   end

   hms_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .in_valid (chain_valid[DIV_CELLS]),
      .in_ready (chain_ready[DIV_CELLS]),
      .in_item  (chain_item[DIV_CELLS]),
      .rsp_ch   (rsp_ch)
   );

endmodule

[rtl/core/hms_checker.sv]
// ----------------------------------------------------------------------------
// hms_checker
// Port-level checks for the homing step core, bound to the top level.
// ----------------------------------------------------------------------------
module hms_checker
   import hms_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [31:0] rsp_tile_index,
   input logic              rsp_tile_valid,
   input logic              rsp_arrived,
   input logic              csr_psel,
   input logic              csr_penable,
   input logic              csr_pwrite,
   input logic [ADDR_W-1:0] csr_paddr,
   input logic [31:0]       csr_pwdata,
   input logic [31:0]       csr_prdata
);

   // no result can come out right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_tile_index)
         && $stable(rsp_arrived))
      else $error("stalled result changed");

   // tile index only carries a value when flagged
   a_tile_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tile_valid |-> rsp_tile_index == '0)
      else $error("tile index set without tile_valid");

   // a written tile size reads back
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite ##1
         (csr_psel && !csr_pwrite && csr_paddr[2] == $past(csr_paddr[2]))
      |-> csr_prdata == {{(32-TILE_W){1'b0}}, $past(csr_pwdata[TILE_W-1:0])})
      else $error("tile size readback mismatch");

endmodule

bind axis_homing_motion_step_core hms_checker u_hms_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_tile_index (rsp_ch.tile_index),
   .rsp_tile_valid (rsp_ch.tile_valid),
   .rsp_arrived    (rsp_ch.arrived),
   .csr_psel       (csr_psel),
   .csr_penable    (csr_penable),
   .csr_pwrite     (csr_pwrite),
   .csr_paddr      (csr_paddr),
   .csr_pwdata     (csr_pwdata),
   .csr_prdata     (csr_prdata)
);

[sim/axis_homing_motion_step_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_homing_motion_step_core_test
// Self-checking bench for the homing step core: drives axis requests with
// random gaps, stalls the result side, predicts every update in the bench
// and compares results in order, field by field, across tile size settings.
// ----------------------------------------------------------------------------
module axis_homing_motion_step_core_test;
   import hms_pkg::*;

   localparam logic [1:0] MODE_Z     = 2'd2;
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [1:0]         mode;
      logic               homing_on;
      logic               axis_on;
      logic signed [31:0] position_now;
      logic signed [31:0] velocity_now;
      logic signed [31:0] accel;
      logic signed [31:0] goal;
   } axis_request_type;

   typedef struct packed {
      logic signed [31:0] position_new;
      logic signed [31:0] velocity_new;
      logic               arrived;
      logic signed [31:0] tile_index;
      logic               tile_valid;
   } axis_update_type;

   logic              clock;
   logic              reset;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   hms_req_if req_bus ();
   hms_rsp_if rsp_bus ();

   axis_homing_motion_step_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bench copy of the tile size registers
   logic [TILE_W-1:0] tile_div_x;
   logic [TILE_W-1:0] tile_div_y;

   axis_update_type expected_updates[$];

   int errors;
   int n_requests;
   int n_checked;
   int n_arrived;
   int n_tiles;
   int n_settings;
   int input_stalls;
   int cycle_count;
   bit sender_gaps_on;
   bit receiver_stalls_on;
   int rsp_hold_len;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic axis_update_type predict_axis_step(axis_request_type r);
      axis_update_type    u;
      logic signed [31:0] pos;
      logic signed [31:0] vel;
      logic signed [31:0] goal;
      logic signed [31:0] step_v;
      logic signed [31:0] moved;
      logic [TILE_W-1:0]  div;
      longint             quot;
      u    = '0;
      pos  = r.position_now;
      vel  = r.velocity_now;
      goal = r.goal;
      if (r.homing_on && r.axis_on) begin
         step_v = r.accel;
         // at or past the goal the acceleration points back
         if (pos >= goal) begin
            step_v = -step_v;
         end
         vel   = vel + step_v;
         moved = pos + vel;
         if ((vel > 0 && moved < goal) || (vel < 0 && moved > goal)) begin
            pos = moved;
         end else begin
            pos       = goal;
            u.arrived = 1'b1;
         end
      end
      if (r.homing_on && (r.mode == MODE_X || r.mode == MODE_Y)) begin
         div = (r.mode == MODE_X) ? tile_div_x : tile_div_y;
         if (div != '0) begin
            quot         = longint'(pos) / longint'({48'd0, div});
            u.tile_index = quot[31:0];
         end
         u.tile_valid = 1'b1;
      end
      u.position_new = pos;
      u.velocity_new = vel;
      return u;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------------
   function automatic axis_request_type make_request(logic [1:0] mode, logic homing_on,
                                                     logic axis_on, logic [31:0] pos,
                                                     logic [31:0] vel, logic [31:0] acc,
                                                     logic [31:0] goal);
      axis_request_type r;
      r.mode         = mode;
      r.homing_on    = homing_on;
      r.axis_on      = axis_on;
      r.position_now = pos;
      r.velocity_now = vel;
      r.accel        = acc;
      r.goal         = goal;
      return r;
   endfunction

   function automatic logic [31:0] random_word();
      logic [31:0] w;
      case ($urandom_range(0, 4))
         0: w = $urandom;
         1: w = 32'(int'($urandom_range(0, 2000)) - 1000);
         2: begin
            case ($urandom_range(0, 3))
               0: w = 32'h7fff_ffff;
               1: w = 32'h8000_0000;
               2: w = 32'h0000_0000;
               default: w = 32'hffff_ffff;
            endcase
         end
         default: w = 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
      return w;
   endfunction

   function automatic axis_request_type random_request();
      axis_request_type r;
      logic [31:0]      goal;
      r.mode      = ($urandom_range(0, 15) == 0) ? MODE_SPARE : 2'($urandom_range(0, 2));
      r.homing_on = ($urandom_range(0, 9) != 0);
      r.axis_on   = ($urandom_range(0, 7) != 0);
      goal        = random_word();
      r.goal      = goal;
      if ($urandom_range(0, 3) != 0) begin
         // an object closing in on its goal: a few ticks out, modest speed
         r.position_now = goal + 32'(int'($urandom_range(0, 4000)) - 2000);
         r.velocity_now = 32'(int'($urandom_range(0, 200)) - 100);
         r.accel        = 32'($urandom_range(0, 20));
      end else begin
         r.position_now = random_word();
         r.velocity_now = random_word();
         r.accel        = random_word();
      end
      return r;
   endfunction

   function automatic logic [TILE_W-1:0] random_tile_size();
      logic [TILE_W-1:0] s;
      case ($urandom_range(0, 3))
         0: s = ($urandom_range(0, 1) != 0) ? 16'd1 : 16'hffff;
         1: s = 16'($urandom_range(1, 64));
         default: s = 16'($urandom_range(1, 65535));
      endcase
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------------
   // write one tile size register, then read it back
   task automatic program_tile_size(logic reg_sel, logic [TILE_W-1:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = ADDR_W'({reg_sel, 2'b00});
      csr_pwdata  = {16'd0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (reg_sel == REG_TILE_X) begin
         tile_div_x = value;
      end else begin
         tile_div_y = value;
      end
      @(negedge clock);
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[TILE_W-1:0] !== value) begin
         errors++;
         $display("%0t: tile size readback mismatch at 0x%0h, expected %0d, actual %0d",
                  $time, csr_paddr, value, csr_prdata[TILE_W-1:0]);
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      n_settings++;
   endtask

   // offer one request and hold it until it is taken
   task automatic send_request(axis_request_type r);
      @(negedge clock);
      if (sender_gaps_on && $urandom_range(0, 7) == 0) begin
         req_bus.valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_bus.mode         = r.mode;
      req_bus.homing_on    = r.homing_on;
      req_bus.axis_on      = r.axis_on;
      req_bus.position_now = r.position_now;
      req_bus.velocity_now = r.velocity_now;
      req_bus.accel        = r.accel;
      req_bus.goal         = r.goal;
      req_bus.valid        = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      expected_updates.push_back(predict_axis_step(r));
      n_requests++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_updates.size() != 0) @(posedge clock);
   endtask

   // result side: random stalls, plus a long hold-off when a test asks for one
   initial begin : result_sink
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_len != 0) begin
            hold_left    = rsp_hold_len;
            rsp_hold_len = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready = 1'b0;
         end else if (receiver_stalls_on && $urandom_range(0, 9) == 0) begin
            stall_left    = $urandom_range(1, 17) - 1;
            rsp_bus.ready = 1'b0;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------
   task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d (0x%h), actual %0d (0x%h)",
                  $time, name, $signed(want), want, $signed(got), got);
      end
   endtask

   always @(posedge clock) begin : update_check
      axis_update_type want;
      if (!reset && req_bus.valid && !req_bus.ready) begin
         input_stalls++;
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_updates.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual position %0d",
                     $time, rsp_bus.position_new);
         end else begin
            want = expected_updates.pop_front();
            n_checked++;
            if (want.arrived) n_arrived++;
            if (want.tile_valid) n_tiles++;
            compare_field("position_new", want.position_new, rsp_bus.position_new);
            compare_field("velocity_new", want.velocity_new, rsp_bus.velocity_new);
            compare_field("arrived", 32'(want.arrived), 32'(rsp_bus.arrived));
            compare_field("tile_index", want.tile_index, rsp_bus.tile_index);
            compare_field("tile_valid", 32'(want.tile_valid), 32'(rsp_bus.tile_valid));
         end
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_updates.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   task automatic test_reset_values();
      // rewriting the reset value also checks readback of the default
      program_tile_size(REG_TILE_X, TILE_SIZE_RESET);
      program_tile_size(REG_TILE_Y, TILE_SIZE_RESET);
   endtask

   task automatic test_directed_cases();
      // homing off passes everything through
      send_request(make_request(MODE_X, 1'b0, 1'b1, 100, 5, 3, 200));
      send_request(make_request(MODE_Z, 1'b0, 1'b0, -5, -7, 9, 40));
      // axis inactive still gives a tile index for x and y
      send_request(make_request(MODE_X, 1'b1, 1'b0, -17, 4, 2, 50));
      send_request(make_request(MODE_Y, 1'b1, 1'b0, 33, -4, 2, -50));
      send_request(make_request(MODE_Z, 1'b1, 1'b0, 33, -4, 2, -50));
      // moving z, and the spare mode that behaves like z
      send_request(make_request(MODE_Z, 1'b1, 1'b1, 0, 10, 1, 1000));
      send_request(make_request(MODE_SPARE, 1'b1, 1'b1, 0, 10, 1, 1000));
      send_request(make_request(MODE_SPARE, 1'b0, 1'b1, 0, 10, 1, 1000));
      // sitting on the goal with no speed
      send_request(make_request(MODE_X, 1'b1, 1'b1, 64, 0, 0, 64));
      // past the goal: acceleration flips sign
      send_request(make_request(MODE_X, 1'b1, 1'b1, 500, 0, 4, 100));
      // overshoot snaps to the goal
      send_request(make_request(MODE_Y, 1'b1, 1'b1, 90, 20, 0, 100));
      // velocity cancels to zero
      send_request(make_request(MODE_Y, 1'b1, 1'b1, 0, -3, 3, 50));
      // wraparound of velocity and position
      send_request(make_request(MODE_X, 1'b1, 1'b1, 32'h7fff_ffff, 32'h7fff_ffff, 1,
                                32'h8000_0000));
      send_request(make_request(MODE_Y, 1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000,
                                32'h8000_0000, 32'h7fff_ffff));
      send_request(make_request(MODE_X, 1'b1, 1'b1, 32'h8000_0000, 32'h7fff_ffff,
                                32'h7fff_ffff, 32'h7fff_ffff));
      // tile truncation toward zero on negative positions
      send_request(make_request(MODE_X, 1'b1, 1'b0, -1, 0, 0, 0));
      send_request(make_request(MODE_Y, 1'b1, 1'b0, 32'h8000_0000, 0, 0, 0));
      send_request(make_request(MODE_SPARE, 1'b1, 1'b1, 32'hffff_ffff, 32'hffff_ffff,
                                32'hffff_ffff, 32'hffff_ffff));
      send_request(make_request(MODE_X, 1'b1, 1'b1, 0, 0, 0, 0));
      wait_idle();
   endtask

   task automatic test_tile_sizes();
      logic [TILE_W-1:0] sizes_x[6];
      logic [TILE_W-1:0] sizes_y[6];
      sizes_x = '{16'd1, 16'hffff, 16'd0, 16'd7, 16'd16, 16'h8000};
      sizes_y = '{16'hffff, 16'd1, 16'd0, 16'd3, 16'd13, 16'h7fff};
      foreach (sizes_x[i]) begin
         program_tile_size(REG_TILE_X, sizes_x[i]);
         program_tile_size(REG_TILE_Y, sizes_y[i]);
         repeat (20) send_request(random_request());
         send_request(make_request(MODE_X, 1'b1, 1'b0, 32'h8000_0000, 0, 0, 0));
         send_request(make_request(MODE_Y, 1'b1, 1'b0, 32'h7fff_ffff, 0, 0, 0));
         wait_idle();
      end
   endtask

   task automatic test_random_traffic();
      repeat (5) begin
         program_tile_size(REG_TILE_X, random_tile_size());
         program_tile_size(REG_TILE_Y, random_tile_size());
         repeat (260) send_request(random_request());
         wait_idle();
      end
   endtask

   task automatic test_backpressure();
      sender_gaps_on = 1'b0;
      send_request(random_request());
      rsp_hold_len = 150;
      repeat (100) send_request(random_request());
      wait_idle();
      sender_gaps_on = 1'b1;
   endtask

   task automatic test_full_rate();
      sender_gaps_on     = 1'b0;
      receiver_stalls_on = 1'b0;
      program_tile_size(REG_TILE_X, random_tile_size());
      program_tile_size(REG_TILE_Y, random_tile_size());
      repeat (150) send_request(random_request());
      wait_idle();
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : main_sequence
      errors             = 0;
      n_requests         = 0;
      n_checked          = 0;
      n_arrived          = 0;
      n_tiles            = 0;
      n_settings         = 0;
      input_stalls       = 0;
      rsp_hold_len       = 0;
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
      tile_div_x         = TILE_SIZE_RESET;
      tile_div_y         = TILE_SIZE_RESET;
      reset              = 1'b1;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;
      req_bus.valid        = 1'b0;
      req_bus.mode         = MODE_X;
      req_bus.homing_on    = 1'b0;
      req_bus.axis_on      = 1'b0;
      req_bus.position_now = '0;
      req_bus.velocity_now = '0;
      req_bus.accel        = '0;
      req_bus.goal         = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_reset_values();
      test_tile_sizes();
      test_random_traffic();
      test_backpressure();
      test_full_rate();

      // let any stray result show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests, %0d results checked (%0d arrivals, %0d tile indexes)",
               n_requests, n_checked, n_arrived, n_tiles);
      $display("%0d tile size writes, %0d cycles of request stall, %0d errors",
               n_settings, input_stalls, errors);
      if (errors == 0 && expected_updates.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/hms_pkg.sv
rtl/core/hms_if.sv
rtl/core/hms_motion.sv
rtl/core/hms_div_cell.sv
rtl/core/hms_finish.sv
rtl/core/axis_homing_motion_step_core.sv
rtl/core/hms_checker.sv
sim/axis_homing_motion_step_core_test.sv
